[src/sur_pkg.sv]
// shared widths, register codes and helpers for the stokes solution pipeline
package sur_pkg;

    localparam int DW      = 32;          // field width, signed q12.20
    localparam int FRAC    = 20;
    localparam int MUL_LAT = 5;           // latency of every product level
    localparam int W_P     = 2 * DW;      // first level products
    localparam int W_G     = W_P + 2;     // g1, g2, g3 sums
    localparam int W_D     = W_P + 1;     // cross differences
    localparam int W_SQ    = 2 * W_G;     // g2 squared
    localparam int W_HX    = W_G + DW;    // widest second level numerator product
    localparam int W_H     = 97;          // numerator terms before source gradient
    localparam int W_DET   = 130;         // determinant
    localparam int W_N     = 128;         // scaled numerators
    localparam int QW      = 34;          // quotient bits
    localparam int DIV_LAT = QW + 4;
    localparam int CFG_IW  = 1;

    localparam logic [CFG_IW-1:0] REG_S0 = 1'b0;
    localparam logic [CFG_IW-1:0] REG_SG = 1'b1;

    function automatic logic signed [DW-1:0] sat32(input logic signed [DW+3:0] v);
        logic signed [DW+3:0] hi;
        logic signed [DW+3:0] lo;
        hi = (DW+4)'(2147483647);
        lo = -(DW+4)'(2147483647) - (DW+4)'(1);
        if (v > hi) begin
            return DW'(hi);
        end else if (v < lo) begin
            return DW'(lo);
        end
        return DW'(v);
    endfunction

endpackage

[src/sur_dly.sv]
// fixed-length delay line that advances with the pipeline enable
module sur_dly #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_d
);

    generate
        if (DEPTH == 0) begin : g_none
            assign o_d = i_d;
        end else begin : g_line
            logic [W-1:0] r_q [DEPTH];
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_q[0] <= i_d;
                    for (int k = 1; k < DEPTH; k++) begin
                        r_q[k] <= r_q[k-1];
                    end
                end
            end
            assign o_d = r_q[DEPTH-1];
        end
    endgenerate

endmodule

[src/sur_mul.sv]
// pipelined signed multiplier, one digit of b per stage, padded to a fixed latency
module sur_mul #(
    parameter int WA  = 32,
    parameter int WB  = 32,
    parameter int CH  = 16,
    parameter int LAT = 5
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [WA-1:0]      i_a,
    input  logic signed [WB-1:0]      i_b,
    output logic signed [WA+WB-1:0]   o_p
);

    localparam int NCH = (WB + CH - 1) / CH;
    localparam int BXW = NCH * CH;
    localparam int PW  = WA + WB;

    logic signed [WA-1:0]  s_a [NCH+1];
    logic signed [BXW-1:0] s_b [NCH+1];
    logic signed [PW-1:0]  s_p [NCH+1];

    assign s_a[0] = i_a;
    assign s_b[0] = BXW'(i_b);
    assign s_p[0] = '0;

    generate
        for (genvar k = 0; k < NCH; k++) begin : g_stg
            logic signed [CH:0]    w_dig;
            logic signed [WA+CH:0] w_pp;
            logic signed [WA-1:0]  r_a;
            logic signed [BXW-1:0] r_b;
            logic signed [PW-1:0]  r_p;

            // top digit carries the sign, lower digits are unsigned
            if (k == NCH - 1) begin : g_top
                assign w_dig = {s_b[k][(k+1)*CH-1], s_b[k][(k+1)*CH-1 -: CH]};
            end else begin : g_low
                assign w_dig = {1'b0, s_b[k][(k+1)*CH-1 -: CH]};
            end
            assign w_pp = s_a[k] * w_dig;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_a <= s_a[k];
                    r_b <= s_b[k];
                    r_p <= s_p[k] + (PW'(w_pp) <<< (k * CH));
                end
            end
            assign s_a[k+1] = r_a;
            assign s_b[k+1] = r_b;
            assign s_p[k+1] = r_p;
        end
    endgenerate

    sur_dly #(.W(PW), .DEPTH(LAT - NCH)) u_pad (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_d   (s_p[NCH]),
        .o_d   (o_p)
    );

endmodule

[src/sur_div.sv]
// pipelined rounding divider lane: round(n * 2^frac / d), magnitude clamped
module sur_div #(
    parameter int NW   = 128,
    parameter int DWD  = 130,
    parameter int FRAC = 20,
    parameter int QW   = 34
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [NW-1:0]  i_num,
    input  logic signed [DWD-1:0] i_den,
    output logic signed [QW:0]    o_ratio,
    output logic                  o_dzero
);

    localparam int XA = NW + FRAC + 1;
    localparam int XW = ((XA > DWD) ? XA : DWD) + 1;
    localparam int RW = DWD + 1;
    localparam logic [QW-1:0] BIG = QW'(1) << (QW - 1);

    typedef struct packed {
        logic neg;
        logic nz;
        logic dz;
        logic ovf;
    } t_dflag;

    logic [NW-1:0]  r_an;
    logic [DWD-1:0] r_ad;
    t_dflag         r_fl_a;
    logic [XW-1:0]  r_x;
    logic [RW-1:0]  r_dv_b;
    t_dflag         r_fl_b;
    logic [RW-1:0]  r_rem_c;
    logic [QW-1:0]  r_low_c;
    logic [RW-1:0]  r_dv_c;
    t_dflag         r_fl_c;
    logic           w_ovf;

    // magnitudes and signs
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_an   <= i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
            r_ad   <= i_den[DWD-1] ? DWD'(-i_den) : DWD'(i_den);
            r_fl_a <= '{neg: i_num[NW-1] ^ i_den[DWD-1],
                        nz:  (i_num == '0),
                        dz:  (i_den == '0),
                        ovf: 1'b0};
        end
    end

    // dividend with half divisor added for rounding, divisor doubled
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= (XW'(r_an) << (FRAC + 1)) + XW'(r_ad);
            r_dv_b <= {r_ad, 1'b0};
            r_fl_b <= r_fl_a;
        end
    end

    // quotient too large for qw bits, also covers a zero divisor
    assign w_ovf = (r_x >> QW) >= XW'(r_dv_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem_c <= RW'(r_x >> QW);
            r_low_c <= r_x[QW-1:0];
            r_dv_c  <= r_dv_b;
            r_fl_c  <= '{neg: r_fl_b.neg, nz: r_fl_b.nz, dz: r_fl_b.dz, ovf: w_ovf};
        end
    end

    logic [RW-1:0] s_rem [QW+1];
    logic [QW-1:0] s_low [QW+1];
    logic [QW-1:0] s_quo [QW+1];
    logic [RW-1:0] s_dv  [QW+1];
    t_dflag        s_fl  [QW+1];

    assign s_rem[0] = r_rem_c;
    assign s_low[0] = r_low_c;
    assign s_quo[0] = '0;
    assign s_dv[0]  = r_dv_c;
    assign s_fl[0]  = r_fl_c;

    generate
        for (genvar k = 0; k < QW; k++) begin : g_bit
            logic [RW:0]   w_t;
            logic          w_ge;
            logic [RW-1:0] r_rem;
            logic [QW-1:0] r_low;
            logic [QW-1:0] r_quo;
            logic [RW-1:0] r_dv;
            t_dflag        r_fl;

            assign w_t  = {s_rem[k], s_low[k][QW-1]};
            assign w_ge = w_t >= {1'b0, s_dv[k]};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem <= w_ge ? RW'(w_t - {1'b0, s_dv[k]}) : RW'(w_t);
                    r_low <= s_low[k] << 1;
                    r_quo <= {s_quo[k][QW-2:0], w_ge};
                    r_dv  <= s_dv[k];
                    r_fl  <= s_fl[k];
                end
            end
            assign s_rem[k+1] = r_rem;
            assign s_low[k+1] = r_low;
            assign s_quo[k+1] = r_quo;
            assign s_dv[k+1]  = r_dv;
            assign s_fl[k+1]  = r_fl;
        end
    endgenerate

    logic [QW-1:0]      w_mag;
    logic signed [QW:0] w_smag;
    logic signed [QW:0] r_ratio;
    logic               r_dzero;

    always_comb begin
        w_mag = s_quo[QW];
        if (s_fl[QW].ovf || s_quo[QW][QW-1]) begin
            w_mag = BIG;
        end
        // zero over zero reads as zero
        if (s_fl[QW].dz && s_fl[QW].nz) begin
            w_mag = '0;
        end
        w_smag = {1'b0, w_mag};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ratio <= s_fl[QW].neg ? -w_smag : w_smag;
            r_dzero <= s_fl[QW].dz;
        end
    end

    assign o_ratio = r_ratio;
    assign o_dzero = r_dzero;

endmodule

[src/stokes_unno_rachkovsky_solution.sv]
// top level: milne-eddington stokes solution pipeline
// Takes one wavelength sample per cycle while o_ready is high and returns I, Q, U, V
// in the same order. A result passes three product levels, two summing stages,
// a 38-stage rounding divider (one quotient bit per stage, four lanes) and the
// output register. The whole pipeline advances together and holds while a
// finished result is not taken, so o_ready drops only then.
// Configuration writes (index 0 source constant, 1 scaled source gradient)
// should be made while no request is in flight.
module stokes_unno_rachkovsky_solution (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [sur_pkg::CFG_IW-1:0]         i_cfg_idx,
    input  logic [sur_pkg::DW-1:0]             i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [sur_pkg::DW-1:0]      i_eta_i,
    input  logic signed [sur_pkg::DW-1:0]      i_eta_q,
    input  logic signed [sur_pkg::DW-1:0]      i_eta_u,
    input  logic signed [sur_pkg::DW-1:0]      i_eta_v,
    input  logic signed [sur_pkg::DW-1:0]      i_rho_q,
    input  logic signed [sur_pkg::DW-1:0]      i_rho_u,
    input  logic signed [sur_pkg::DW-1:0]      i_rho_v,
    input  logic                               i_last_in,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [sur_pkg::DW-1:0]      o_stokes_i,
    output logic signed [sur_pkg::DW-1:0]      o_stokes_q,
    output logic signed [sur_pkg::DW-1:0]      o_stokes_u,
    output logic signed [sur_pkg::DW-1:0]      o_stokes_v,
    output logic                               o_singular,
    output logic                               o_last_out
);
    import sur_pkg::*;

    localparam int VL = 3 * MUL_LAT + 2 + DIV_LAT;
    localparam int NA = 16;

    logic               w_en;
    logic [VL-1:0]      r_vld;
    logic [VL-1:0]      n_vld;
    logic signed [DW-1:0] r_s0;
    logic signed [DW-1:0] r_sg;
    logic               r_out_vld;

    assign w_en    = !r_out_vld || i_ready;
    assign o_ready = w_en;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0 <= '0;
            r_sg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_S0:  r_s0 <= i_cfg_data;
                REG_SG:  r_sg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign n_vld = {r_vld[VL-2:0], i_valid && w_en};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= n_vld;
        end
    end

    // level a: squares of the inputs and the eta-rho cross products
    logic signed [DW-1:0]  ma_a [NA];
    logic signed [DW-1:0]  ma_b [NA];
    logic signed [W_P-1:0] pa   [NA];

    assign ma_a[0]  = i_eta_i; assign ma_b[0]  = i_eta_i;
    assign ma_a[1]  = i_eta_q; assign ma_b[1]  = i_eta_q;
    assign ma_a[2]  = i_eta_u; assign ma_b[2]  = i_eta_u;
    assign ma_a[3]  = i_eta_v; assign ma_b[3]  = i_eta_v;
    assign ma_a[4]  = i_rho_q; assign ma_b[4]  = i_rho_q;
    assign ma_a[5]  = i_rho_u; assign ma_b[5]  = i_rho_u;
    assign ma_a[6]  = i_rho_v; assign ma_b[6]  = i_rho_v;
    assign ma_a[7]  = i_eta_q; assign ma_b[7]  = i_rho_q;
    assign ma_a[8]  = i_eta_u; assign ma_b[8]  = i_rho_u;
    assign ma_a[9]  = i_eta_v; assign ma_b[9]  = i_rho_v;
    assign ma_a[10] = i_eta_v; assign ma_b[10] = i_rho_u;
    assign ma_a[11] = i_eta_u; assign ma_b[11] = i_rho_v;
    assign ma_a[12] = i_eta_q; assign ma_b[12] = i_rho_v;
    assign ma_a[13] = i_eta_v; assign ma_b[13] = i_rho_q;
    assign ma_a[14] = i_eta_u; assign ma_b[14] = i_rho_q;
    assign ma_a[15] = i_eta_q; assign ma_b[15] = i_rho_u;

    generate
        for (genvar k = 0; k < NA; k++) begin : g_ma
            sur_mul #(.WA(DW), .WB(DW), .CH(DW), .LAT(MUL_LAT)) u_mul (
                .i_clk (i_clk), .i_en (w_en),
                .i_a (ma_a[k]), .i_b (ma_b[k]), .o_p (pa[k])
            );
        end
    endgenerate

    logic [7*DW-1:0] w_in_d;

    sur_dly #(.W(7 * DW), .DEPTH(MUL_LAT)) u_in_dly (
        .i_clk (i_clk), .i_en (w_en),
        .i_d   ({i_eta_i, i_eta_q, i_eta_u, i_eta_v, i_rho_q, i_rho_u, i_rho_v}),
        .o_d   (w_in_d)
    );

    // stage 1: g sums and cross differences
    logic signed [W_P-1:0] r1_ei2;
    logic signed [W_G-1:0] r1_g1, r1_g2, r1_g3;
    logic signed [W_D-1:0] r1_d4, r1_d5, r1_d6;
    logic signed [DW-1:0]  r1_ei, r1_eq, r1_eu, r1_ev, r1_rq, r1_ru, r1_rv;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_ei2 <= pa[0];
            r1_g1  <= W_G'(pa[0]) - W_G'(pa[1]) - W_G'(pa[2]) - W_G'(pa[3])
                    + W_G'(pa[4]) + W_G'(pa[5]) + W_G'(pa[6]);
            r1_g2  <= W_G'(pa[7]) + W_G'(pa[8]) + W_G'(pa[9]);
            r1_g3  <= W_G'(pa[0]) + W_G'(pa[4]) + W_G'(pa[5]) + W_G'(pa[6]);
            r1_d4  <= W_D'(pa[10]) - W_D'(pa[11]);
            r1_d5  <= W_D'(pa[12]) - W_D'(pa[13]);
            r1_d6  <= W_D'(pa[14]) - W_D'(pa[15]);
            {r1_ei, r1_eq, r1_eu, r1_ev, r1_rq, r1_ru, r1_rv} <= w_in_d;
        end
    end

    // level b
    logic signed [W_G+W_P-1:0] pb_det1;
    logic signed [W_SQ-1:0]    pb_g2sq;
    logic signed [W_P+DW-1:0]  pb_eq, pb_eu, pb_ev;
    logic signed [W_D+DW-1:0]  pb_d4, pb_d5, pb_d6;
    logic signed [W_HX-1:0]    pb_g3, pb_rq, pb_ru, pb_rv;

    sur_mul #(.WA(W_G), .WB(W_P), .CH(16), .LAT(MUL_LAT)) u_mb_det1 (
        .i_clk (i_clk), .i_en (w_en), .i_a (r1_g1), .i_b (r1_ei2), .o_p (pb_det1));
    sur_mul #(.WA(W_G), .WB(W_G), .CH(16), .LAT(MUL_LAT)) u_mb_g2sq (
        .i_clk (i_clk), .i_en (w_en), .i_a (r1_g2), .i_b (r1_g2), .o_p (pb_g2sq));
    sur_mul #(.WA(W_P), .WB(DW), .CH(16), .LAT(MUL_LAT)) u_mb_eq (
        .i_clk (i_clk), .i_en (w_en), .i_a (r1_ei2), .i_b (r1_eq), .o_p (pb_eq));
    sur_mul #(.WA(W_P), .WB(DW), .CH(16), .LAT(MUL_LAT)) u_mb_eu (
        .i_clk (i_clk), .i_en (w_en), .i_a (r1_ei2), .i_b (r1_eu), .o_p (pb_eu));
    sur_mul #(.WA(W_P), .WB(DW), .CH(16), .LAT(MUL_LAT)) u_mb_ev (
        .i_clk (i_clk), .i_en (w_en), .i_a (r1_ei2), .i_b (r1_ev), .o_p (pb_ev));
    sur_mul #(.WA(W_D), .WB(DW), .CH(16), .LAT(MUL_LAT)) u_mb_d4 (
        .i_clk (i_clk), .i_en (w_en), .i_a (r1_d4), .i_b (r1_ei), .o_p (pb_d4));
    sur_mul #(.WA(W_D), .WB(DW), .CH(16), .LAT(MUL_LAT)) u_mb_d5 (
        .i_clk (i_clk), .i_en (w_en), .i_a (r1_d5), .i_b (r1_ei), .o_p (pb_d5));
    sur_mul #(.WA(W_D), .WB(DW), .CH(16), .LAT(MUL_LAT)) u_mb_d6 (
        .i_clk (i_clk), .i_en (w_en), .i_a (r1_d6), .i_b (r1_ei), .o_p (pb_d6));
    sur_mul #(.WA(W_G), .WB(DW), .CH(16), .LAT(MUL_LAT)) u_mb_g3 (
        .i_clk (i_clk), .i_en (w_en), .i_a (r1_g3), .i_b (r1_ei), .o_p (pb_g3));
    sur_mul #(.WA(W_G), .WB(DW), .CH(16), .LAT(MUL_LAT)) u_mb_rq (
        .i_clk (i_clk), .i_en (w_en), .i_a (r1_g2), .i_b (r1_rq), .o_p (pb_rq));
    sur_mul #(.WA(W_G), .WB(DW), .CH(16), .LAT(MUL_LAT)) u_mb_ru (
        .i_clk (i_clk), .i_en (w_en), .i_a (r1_g2), .i_b (r1_ru), .o_p (pb_ru));
    sur_mul #(.WA(W_G), .WB(DW), .CH(16), .LAT(MUL_LAT)) u_mb_rv (
        .i_clk (i_clk), .i_en (w_en), .i_a (r1_g2), .i_b (r1_rv), .o_p (pb_rv));

    // stage 2: determinant and numerator terms
    logic signed [W_DET-1:0] r2_det;
    logic signed [W_H-1:0]   r2_hi, r2_hq, r2_hu, r2_hv;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_det <= W_DET'(W_SQ'(pb_det1) - pb_g2sq);
            r2_hi  <= W_H'(pb_g3);
            r2_hq  <= W_H'(W_HX'(pb_eq) + W_HX'(pb_d4) + pb_rq);
            r2_hu  <= W_H'(W_HX'(pb_eu) + W_HX'(pb_d5) + pb_ru);
            r2_hv  <= W_H'(W_HX'(pb_ev) + W_HX'(pb_d6) + pb_rv);
        end
    end

    // level c: scale by source gradient
    logic signed [W_H+DW-1:0] pc_i, pc_q, pc_u, pc_v;
    logic [W_DET-1:0]         w_det_d;

    sur_mul #(.WA(W_H), .WB(DW), .CH(8), .LAT(MUL_LAT)) u_mc_i (
        .i_clk (i_clk), .i_en (w_en), .i_a (r2_hi), .i_b (r_sg), .o_p (pc_i));
    sur_mul #(.WA(W_H), .WB(DW), .CH(8), .LAT(MUL_LAT)) u_mc_q (
        .i_clk (i_clk), .i_en (w_en), .i_a (r2_hq), .i_b (r_sg), .o_p (pc_q));
    sur_mul #(.WA(W_H), .WB(DW), .CH(8), .LAT(MUL_LAT)) u_mc_u (
        .i_clk (i_clk), .i_en (w_en), .i_a (r2_hu), .i_b (r_sg), .o_p (pc_u));
    sur_mul #(.WA(W_H), .WB(DW), .CH(8), .LAT(MUL_LAT)) u_mc_v (
        .i_clk (i_clk), .i_en (w_en), .i_a (r2_hv), .i_b (r_sg), .o_p (pc_v));

    sur_dly #(.W(W_DET), .DEPTH(MUL_LAT)) u_det_dly (
        .i_clk (i_clk), .i_en (w_en), .i_d (r2_det), .o_d (w_det_d));

    // divider lanes
    logic signed [QW:0] w_rat_i, w_rat_q, w_rat_u, w_rat_v;
    logic               w_dz_i, w_dz_q, w_dz_u, w_dz_v;

    sur_div #(.NW(W_N), .DWD(W_DET), .FRAC(FRAC), .QW(QW)) u_div_i (
        .i_clk (i_clk), .i_en (w_en), .i_num (W_N'(pc_i)), .i_den (w_det_d),
        .o_ratio (w_rat_i), .o_dzero (w_dz_i));
    sur_div #(.NW(W_N), .DWD(W_DET), .FRAC(FRAC), .QW(QW)) u_div_q (
        .i_clk (i_clk), .i_en (w_en), .i_num (W_N'(pc_q)), .i_den (w_det_d),
        .o_ratio (w_rat_q), .o_dzero (w_dz_q));
    sur_div #(.NW(W_N), .DWD(W_DET), .FRAC(FRAC), .QW(QW)) u_div_u (
        .i_clk (i_clk), .i_en (w_en), .i_num (W_N'(pc_u)), .i_den (w_det_d),
        .o_ratio (w_rat_u), .o_dzero (w_dz_u));
    sur_div #(.NW(W_N), .DWD(W_DET), .FRAC(FRAC), .QW(QW)) u_div_v (
        .i_clk (i_clk), .i_en (w_en), .i_num (W_N'(pc_v)), .i_den (w_det_d),
        .o_ratio (w_rat_v), .o_dzero (w_dz_v));

    logic w_last_d;

    sur_dly #(.W(1), .DEPTH(VL)) u_last_dly (
        .i_clk (i_clk), .i_en (w_en), .i_d (i_last_in), .o_d (w_last_d));

    // output register
    logic signed [DW-1:0] r_si, r_sq, r_su, r_sv;
    logic                 r_sing, r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_vld[VL-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_si   <= sat32((DW+4)'(r_s0) - (DW+4)'(w_rat_i));
            r_sq   <= sat32((DW+4)'(w_rat_q));
            r_su   <= sat32((DW+4)'(w_rat_u));
            r_sv   <= sat32((DW+4)'(w_rat_v));
            r_sing <= w_dz_i && w_dz_q && w_dz_u && w_dz_v;
            r_last <= w_last_d;
        end
    end

    assign o_valid    = r_out_vld;
    assign o_stokes_i = r_si;
    assign o_stokes_q = r_sq;
    assign o_stokes_u = r_su;
    assign o_stokes_v = r_sv;
    assign o_singular = r_sing;
    assign o_last_out = r_last;

    localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

    // a singular sample only ever gives saturated or zero polarization
    a_sing_quv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular |->
            (o_stokes_q == SMAX || o_stokes_q == SMIN || o_stokes_q == '0) &&
            (o_stokes_u == SMAX || o_stokes_u == SMIN || o_stokes_u == '0) &&
            (o_stokes_v == SMAX || o_stokes_v == SMIN || o_stokes_v == '0))
        else $error("singular sample with unsaturated polarization");

    // a singular intensity is a rail or the source constant
    a_sing_i: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular |->
            (o_stokes_i == SMAX || o_stokes_i == SMIN || o_stokes_i == r_s0))
        else $error("singular sample with unexpected intensity");

    // while the output waits, no request moves along the pipeline
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |=> $stable(r_vld))
        else $error("pipeline moved during a stall");

endmodule
